// ===== hdl/ahpn_pkg.sv =====
// ahpn_pkg: shared constants and controller/datapath interface types
// for the high-pass peak normaliser; no dependencies
`timescale 1ns / 1ps

package ahpn_pkg;

	// default parameter values
	localparam int CHUNK_MAX_DEF   = 64;
	localparam int SAMPLE_BITS_DEF = 16;

	// configuration port geometry
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HP_COEF    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET     = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOOR      = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LIMIT = 8'd3;

	// register widths and reset values
	localparam int LEVEL_W = 15;
	localparam int GAIN_W  = 16;
	localparam logic [LEVEL_W-1:0] HP_COEF_RST    = 15'd31752;
	localparam logic [LEVEL_W-1:0] TARGET_RST     = 15'd29491;
	localparam logic [LEVEL_W-1:0] FLOOR_RST      = 15'd3;
	localparam logic [GAIN_W-1:0]  GAIN_LIMIT_RST = 16'd40960;

	// fixed point
	localparam int COEF_FRAC = 15;
	localparam int GAIN_FRAC = 12;
	localparam logic [GAIN_W-1:0] GAIN_ONE = 16'd4096;

	// gain divider: (target << 12) / peak, one quotient bit per cycle
	localparam int DIVD_W  = LEVEL_W + GAIN_FRAC;
	localparam int DIVCNT_W = $clog2(DIVD_W + 1);

	// controller to datapath
	typedef struct packed {
		logic take_in;    // register filter product of an accepted sample
		logic commit;     // store filtered sample, update peak and history
		logic div_load;   // start gain division
		logic div_step;   // one quotient bit
		logic set_unity;  // gain of one
		logic cap_gain;   // gain = min(quotient, limit)
		logic rd_issue;   // read chunk store at emit index
		logic mul_out;    // register gain product
		logic load_out;   // load output register, advance emit index
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic end_chunk;   // sample in flight ends the chunk
		logic gain_needed; // floor < peak < target
		logic div_done;
		logic out_free;    // output register can take a result
		logic emit_last;   // emit index is the chunk's final sample
	} sts_t;

endpackage

// ===== hdl/ahpn_ram.sv =====
// ahpn_ram: generic single write, single read RAM with registered read
// no dependencies
`timescale 1ns / 1ps

module ahpn_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/ahpn_datapath.sv =====
// ahpn_datapath: filter, chunk store, peak tracking, gain divider,
// output scaling and output register; uses ahpn_pkg and ahpn_ram
`timescale 1ns / 1ps

module ahpn_datapath #(
	parameter int CHUNK_MAX   = ahpn_pkg::CHUNK_MAX_DEF,
	parameter int SAMPLE_BITS = ahpn_pkg::SAMPLE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ahpn_pkg::cmd_t                     cmd,
	output ahpn_pkg::sts_t                     sts,
	input  logic signed [SAMPLE_BITS-1:0]      in_sample,
	input  logic                               in_end,
	input  logic                               cfg_valid,
	input  logic [ahpn_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ahpn_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [SAMPLE_BITS-1:0]      out_sample,
	output logic [ahpn_pkg::GAIN_W-1:0]        out_gain,
	output logic                               out_last
);

	localparam int SB   = SAMPLE_BITS;
	localparam int FB   = SB + 2;                   // filter state
	localparam int DW   = FB + 1;                   // filter difference
	localparam int FPW  = DW + ahpn_pkg::LEVEL_W + 1;
	localparam int FRW  = FPW - ahpn_pkg::COEF_FRAC;
	localparam int EPW  = FB + ahpn_pkg::GAIN_W + 1;
	localparam int ERW  = EPW - ahpn_pkg::GAIN_FRAC;
	localparam int LW   = ahpn_pkg::LEVEL_W;
	localparam int GW   = ahpn_pkg::GAIN_W;
	localparam int PKW  = (FB > LW) ? FB : LW;
	localparam int CW   = $clog2(CHUNK_MAX + 1);
	localparam int AW   = (CHUNK_MAX > 1) ? $clog2(CHUNK_MAX) : 1;
	localparam int QW   = ahpn_pkg::DIVD_W;

	localparam logic signed [FRW-1:0] F_HI = FRW'(2 ** (FB - 1) - 1);
	localparam logic signed [FRW-1:0] F_LO = -F_HI - FRW'(1);
	localparam logic signed [ERW-1:0] E_HI = ERW'(2 ** (SB - 1) - 1);
	localparam logic signed [ERW-1:0] E_LO = -E_HI - ERW'(1);
	localparam logic signed [FPW-1:0] F_HALF = FPW'(2 ** (ahpn_pkg::COEF_FRAC - 1));
	localparam logic signed [EPW-1:0] E_HALF = EPW'(2 ** (ahpn_pkg::GAIN_FRAC - 1));

	// configuration registers
	logic [LW-1:0] hp_coef_q, target_q, floor_q;
	logic [GW-1:0] gain_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_coef_q    <= ahpn_pkg::HP_COEF_RST;
			target_q     <= ahpn_pkg::TARGET_RST;
			floor_q      <= ahpn_pkg::FLOOR_RST;
			gain_limit_q <= ahpn_pkg::GAIN_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				ahpn_pkg::CFG_HP_COEF:    hp_coef_q    <= cfg_data[LW-1:0];
				ahpn_pkg::CFG_TARGET:     target_q     <= cfg_data[LW-1:0];
				ahpn_pkg::CFG_FLOOR:      floor_q      <= cfg_data[LW-1:0];
				ahpn_pkg::CFG_GAIN_LIMIT: gain_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// filter history and chunk state
	logic signed [SB-1:0] prev_raw_q;
	logic signed [FB-1:0] prev_filt_q;
	logic [FB-1:0]        peak_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        idx_q;

	// filter multiply: a * (y_prev + x - x_prev)
	logic signed [DW-1:0]  diff;
	logic signed [FPW-1:0] fprod;
	logic signed [FPW-1:0] fprod_s1;
	logic signed [SB-1:0]  x_s1;
	logic                  last_s1;

	assign diff  = DW'(prev_filt_q) + DW'(in_sample) - DW'(prev_raw_q);
	assign fprod = FPW'(diff) * FPW'($signed({1'b0, hp_coef_q}));

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			fprod_s1 <= fprod;
			x_s1     <= in_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_s1 <= 1'b0;
		end else if (cmd.take_in) begin
			last_s1 <= in_end;
		end
	end

	// round half up, saturate to filter width
	logic signed [FPW-1:0] fsum;
	logic signed [FRW-1:0] frnd;
	logic signed [FB-1:0]  y;
	logic [FB-1:0]         mag;

	assign fsum = fprod_s1 + F_HALF;
	assign frnd = fsum[FPW-1:ahpn_pkg::COEF_FRAC];

	always_comb begin
		if (frnd > F_HI) begin
			y = F_HI[FB-1:0];
		end else if (frnd < F_LO) begin
			y = F_LO[FB-1:0];
		end else begin
			y = frnd[FB-1:0];
		end
	end

	assign mag = y[FB-1] ? FB'(-y) : y;

	// chunk store
	logic [FB-1:0] rd_data;

	ahpn_ram #(
		.WIDTH (FB),
		.DEPTH (CHUNK_MAX)
	) u_store (
		.clk   (clk),
		.we    (cmd.commit),
		.waddr (count_q[AW-1:0]),
		.wdata (y),
		.re    (cmd.rd_issue),
		.raddr (idx_q[AW-1:0]),
		.rdata (rd_data)
	);

	// gain divider, restoring, one quotient bit per step
	logic [PKW-1:0]               rem_q;
	logic [QW-1:0]                quo_q;
	logic [ahpn_pkg::DIVCNT_W-1:0] div_cnt_q;
	logic [PKW:0]                 trial;
	logic                         trial_ge;
	logic [GW-1:0]                gain_q;

	assign trial    = {rem_q, quo_q[QW-1]};
	assign trial_ge = trial >= (PKW + 1)'(peak_q);

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rem_q <= '0;
			quo_q <= {target_q, ahpn_pkg::GAIN_FRAC'(0)};
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? PKW'(trial - (PKW + 1)'(peak_q)) : trial[PKW-1:0];
			quo_q <= {quo_q[QW-2:0], trial_ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_load) begin
			div_cnt_q <= ahpn_pkg::DIVCNT_W'(QW);
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q - 1'b1;
		end
	end

	// chosen gain
	always_ff @(posedge clk) begin
		if (cmd.set_unity) begin
			gain_q <= ahpn_pkg::GAIN_ONE;
		end else if (cmd.cap_gain) begin
			gain_q <= (quo_q > QW'(gain_limit_q)) ? gain_limit_q : quo_q[GW-1:0];
		end
	end

	// history, peak, fill count and emit index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_raw_q  <= '0;
			prev_filt_q <= '0;
			peak_q      <= '0;
			count_q     <= '0;
			idx_q       <= '0;
		end else if (cmd.commit) begin
			prev_raw_q  <= x_s1;
			prev_filt_q <= y;
			count_q     <= count_q + 1'b1;
			if (mag > peak_q) begin
				peak_q <= mag;
			end
		end else if (cmd.load_out) begin
			if (sts.emit_last) begin
				count_q <= '0;
				peak_q  <= '0;
				idx_q   <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// gain product of a stored sample
	logic signed [EPW-1:0] eprod_s1;

	always_ff @(posedge clk) begin
		if (cmd.mul_out) begin
			eprod_s1 <= EPW'($signed(rd_data)) * EPW'($signed({1'b0, gain_q}));
		end
	end

	// round half up, saturate to sample width
	logic signed [EPW-1:0] esum;
	logic signed [ERW-1:0] ernd;
	logic signed [SB-1:0]  escaled;

	assign esum = eprod_s1 + E_HALF;
	assign ernd = esum[EPW-1:ahpn_pkg::GAIN_FRAC];

	always_comb begin
		if (ernd > E_HI) begin
			escaled = E_HI[SB-1:0];
		end else if (ernd < E_LO) begin
			escaled = E_LO[SB-1:0];
		end else begin
			escaled = ernd[SB-1:0];
		end
	end

	// output register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_sample <= escaled;
			out_gain   <= gain_q;
			out_last   <= sts.emit_last;
		end
	end

	assign out_valid = out_valid_q;

	// status
	assign sts.end_chunk   = last_s1 || (count_q == CW'(CHUNK_MAX - 1));
	assign sts.gain_needed = (PKW'(peak_q) > PKW'(floor_q)) && (PKW'(peak_q) < PKW'(target_q));
	assign sts.div_done    = (div_cnt_q == '0);
	assign sts.out_free    = !out_valid_q || out_ready;
	assign sts.emit_last   = (idx_q == count_q - 1'b1);

endmodule

// ===== hdl/ahpn_ctrl.sv =====
// ahpn_ctrl: sequencing state machine for sample intake, gain choice
// and chunk emission; uses ahpn_pkg command and status types
`timescale 1ns / 1ps

module ahpn_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output ahpn_pkg::cmd_t cmd,
	input  ahpn_pkg::sts_t sts
);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_FILT   = 8'b0000_0010,
		ST_DECIDE = 8'b0000_0100,
		ST_DIV    = 8'b0000_1000,
		ST_CAP    = 8'b0001_0000,
		ST_RD     = 8'b0010_0000,
		ST_MUL    = 8'b0100_0000,
		ST_OUT    = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_in = 1'b1;
					state_d     = ST_FILT;
				end
			end
			ST_FILT: begin
				cmd.commit = 1'b1;
				state_d    = sts.end_chunk ? ST_DECIDE : ST_IDLE;
			end
			ST_DECIDE: begin
				if (sts.gain_needed) begin
					cmd.div_load = 1'b1;
					state_d      = ST_DIV;
				end else begin
					cmd.set_unity = 1'b1;
					state_d       = ST_RD;
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					state_d = ST_CAP;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_CAP: begin
				cmd.cap_gain = 1'b1;
				state_d      = ST_RD;
			end
			ST_RD: begin
				cmd.rd_issue = 1'b1;
				state_d      = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_out = 1'b1;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = sts.emit_last ? ST_IDLE : ST_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/audio_highpass_peak_normalizer.sv =====
// audio_highpass_peak_normalizer: top level, streaming ports and config port
// depends on ahpn_pkg, ahpn_ctrl, ahpn_datapath (which holds ahpn_ram)
`timescale 1ns / 1ps

// DC-blocking first-order high-pass with per-chunk peak normalisation.
// Each input sample is handled in turn: the filter multiply in the cycle it
// is accepted, then the rounded, saturated result is written to the chunk
// store and the peak updated; the next sample is taken only after that. A
// chunk ends on tlast or when the store holds CHUNK_MAX samples. Then a
// decide state chooses the gain; when the peak lies strictly between
// floor_peak and target_peak a bit-serial divider (27 quotient bits and a
// done check) and a limit step follow. Every stored sample is then emitted
// by a store read, a gain multiply and the output register, which may wait
// on a downstream stall, with tlast on the final one. No input is taken between a
// chunk's end and the loading of its final result; the output register lets
// the next chunk start while that result waits. Filter state carries over
// between chunks. Registers: 0 hp_coefficient, 1 target_peak, 2 floor_peak,
// 3 gain_limit; writes to other indexes are ignored.
module audio_highpass_peak_normalizer #(
	parameter int CHUNK_MAX   = ahpn_pkg::CHUNK_MAX_DEF,
	parameter int SAMPLE_BITS = ahpn_pkg::SAMPLE_BITS_DEF,
	localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((SAMPLE_BITS + ahpn_pkg::GAIN_W + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input samples
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [IN_W-1:0]                 s_tdata,  // sample_in
	input  logic                            s_tlast,  // chunk_end
	// output samples
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [OUT_W-1:0]                m_tdata,  // sample_out, gain_applied
	output logic                            m_tlast,  // last_out
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ahpn_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ahpn_pkg::CFG_DATA_W-1:0] cfg_data
);

	ahpn_pkg::cmd_t cmd;
	ahpn_pkg::sts_t sts;

	logic signed [SAMPLE_BITS-1:0]  out_sample;
	logic [ahpn_pkg::GAIN_W-1:0]    out_gain;

	// configuration is always taken
	assign cfg_ready = 1'b1;

	ahpn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	ahpn_datapath #(
		.CHUNK_MAX   (CHUNK_MAX),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_sample  ($signed(s_tdata[SAMPLE_BITS-1:0])),
		.in_end     (s_tlast),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_sample (out_sample),
		.out_gain   (out_gain),
		.out_last   (m_tlast)
	);

	// pack output fields, zero pad to whole bytes
	assign m_tdata = OUT_W'({out_gain, out_sample});

endmodule

// ===== dv/ahpn_result_checker.sv =====
// ahpn_result_checker: watches the sample, result and register channels of the
// high-pass peak normaliser, predicts every result and compares field by field
// depends on ahpn_pkg
`timescale 1ns / 1ps

module ahpn_result_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [15:0]                     s_tdata,  // sample_in
	input  logic                            s_tlast,  // chunk_end
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [31:0]                     m_tdata,  // sample_out, gain_applied
	input  logic                            m_tlast,  // last_out
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [ahpn_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ahpn_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              fail_count,
	output int                              outstanding,
	output int                              samples_taken,
	output int                              results_checked,
	output int                              chunks_closed,
	output int                              chunks_scaled
);

	localparam int SMP_W       = ahpn_pkg::SAMPLE_BITS_DEF;
	localparam int FILT_W      = SMP_W + 2;
	localparam int STORE_DEPTH = ahpn_pkg::CHUNK_MAX_DEF;
	localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int LVL_W       = ahpn_pkg::LEVEL_W;
	localparam int G_W         = ahpn_pkg::GAIN_W;

	typedef struct packed {
		logic [SMP_W-1:0] sample;
		logic [G_W-1:0]   gain;
		logic             last;
	} out_sample_t;

	// register copies
	logic [LVL_W-1:0] hp_coef;
	logic [LVL_W-1:0] target_lvl;
	logic [LVL_W-1:0] floor_lvl;
	logic [G_W-1:0]   gain_cap;

	// filter history and current chunk
	longint last_raw;
	longint last_filt;
	longint run_peak;
	longint chunk_buf [STORE_DEPTH];
	int     chunk_len;

	out_sample_t expected_out [$];

	function automatic longint saturate(input longint v, input int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	// filter one sample, store it, and on chunk close queue the scaled chunk
	task automatic absorb_sample(input logic signed [SMP_W-1:0] x_in, input logic end_mark);
		longint      x;
		longint      diff;
		longint      y;
		longint      mag;
		longint      g;
		longint      v;
		out_sample_t r;
		x = longint'(x_in);
		diff = last_filt + x - last_raw;
		y = saturate((diff * longint'(hp_coef)
			+ (longint'(1) <<< (ahpn_pkg::COEF_FRAC - 1))) >>> ahpn_pkg::COEF_FRAC, FILT_W);
		last_raw = x;
		last_filt = y;
		chunk_buf[IDX_W'(chunk_len)] = y;
		chunk_len++;
		samples_taken++;
		mag = (y < 0) ? -y : y;
		if (mag > run_peak)
			run_peak = mag;
		if (!end_mark && chunk_len < STORE_DEPTH)
			return;

		// one gain for the whole chunk
		if (run_peak > longint'(floor_lvl) && run_peak < longint'(target_lvl)) begin
			g = (longint'(target_lvl) <<< ahpn_pkg::GAIN_FRAC) / run_peak;
			if (g > longint'(gain_cap))
				g = longint'(gain_cap);
		end else begin
			g = longint'(ahpn_pkg::GAIN_ONE);
		end
		for (int i = 0; i < chunk_len; i++) begin
			v = saturate((chunk_buf[IDX_W'(i)] * g
				+ (longint'(1) <<< (ahpn_pkg::GAIN_FRAC - 1))) >>> ahpn_pkg::GAIN_FRAC,
				SMP_W);
			r.sample = v[SMP_W-1:0];
			r.gain = g[G_W-1:0];
			r.last = (i == chunk_len - 1);
			expected_out.push_back(r);
		end
		chunks_closed++;
		if (g != longint'(ahpn_pkg::GAIN_ONE))
			chunks_scaled++;
		chunk_len = 0;
		run_peak = 0;
	endtask

	task automatic check_result(input logic [SMP_W-1:0] smp, input logic [G_W-1:0] g,
		input logic lst);
		out_sample_t e;
		results_checked++;
		if (expected_out.size() == 0) begin
			$error("unexpected result: sample_out %0d gain_applied %0d last_out %0b",
				$signed(smp), g, lst);
			fail_count++;
			return;
		end
		e = expected_out.pop_front();
		if (smp !== e.sample) begin
			$error("sample_out: expected %0d, actual %0d", $signed(e.sample), $signed(smp));
			fail_count++;
		end
		if (g !== e.gain) begin
			$error("gain_applied: expected %0d, actual %0d", e.gain, g);
			fail_count++;
		end
		if (lst !== e.last) begin
			$error("last_out: expected %0b, actual %0b", e.last, lst);
			fail_count++;
		end
	endtask

	// watch every channel at the clock edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_coef = ahpn_pkg::HP_COEF_RST;
			target_lvl = ahpn_pkg::TARGET_RST;
			floor_lvl = ahpn_pkg::FLOOR_RST;
			gain_cap = ahpn_pkg::GAIN_LIMIT_RST;
			last_raw = 0;
			last_filt = 0;
			run_peak = 0;
			chunk_len = 0;
			expected_out.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ahpn_pkg::CFG_HP_COEF:    hp_coef = cfg_data[LVL_W-1:0];
					ahpn_pkg::CFG_TARGET:     target_lvl = cfg_data[LVL_W-1:0];
					ahpn_pkg::CFG_FLOOR:      floor_lvl = cfg_data[LVL_W-1:0];
					ahpn_pkg::CFG_GAIN_LIMIT: gain_cap = cfg_data[G_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready)
				check_result(m_tdata[SMP_W-1:0], m_tdata[SMP_W +: G_W], m_tlast);
			if (s_tvalid && s_tready)
				absorb_sample(s_tdata[SMP_W-1:0], s_tlast);
			outstanding <= expected_out.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
// testbench: drives samples, register writes and downstream stalls into the
// high-pass peak normaliser and reports the verdict
// depends on ahpn_pkg, audio_highpass_peak_normalizer, ahpn_result_checker
`timescale 1ns / 1ps

module testbench;

	localparam int LIMIT_NS   = 1_000_000;
	localparam int LONG_HOLD  = 300;
	localparam int SETTLE     = 10;
	localparam int RAND_SETS  = 5;
	localparam int RAND_ITEMS = 18;

	// indexes outside the register list, writes there are dropped
	localparam logic [ahpn_pkg::CFG_IDX_W-1:0] CFG_SPARE     = 8'd4;
	localparam logic [ahpn_pkg::CFG_IDX_W-1:0] CFG_TOP_INDEX = 8'hFF;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [15:0]                     s_tdata;  // sample_in
	logic                            s_tlast;  // chunk_end
	logic                            m_tvalid;
	logic                            m_tready;
	logic [31:0]                     m_tdata;  // sample_out, gain_applied
	logic                            m_tlast;  // last_out
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [ahpn_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [ahpn_pkg::CFG_DATA_W-1:0] cfg_data;

	int fail_count;
	int outstanding;
	int samples_taken;
	int results_checked;
	int chunks_closed;
	int chunks_scaled;

	bit idle_en;
	bit hold_req;

	audio_highpass_peak_normalizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ahpn_result_checker result_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tlast         (s_tlast),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tlast         (m_tlast),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.outstanding     (outstanding),
		.samples_taken   (samples_taken),
		.results_checked (results_checked),
		.chunks_closed   (chunks_closed),
		.chunks_scaled   (chunks_scaled)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// offer one sample, with an occasional gap before it
	task automatic send_sample(input logic signed [15:0] smp, input logic lst);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= smp;
		s_tlast <= lst;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [ahpn_pkg::CFG_IDX_W-1:0] idx,
		input logic [ahpn_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// stop offering and wait until every queued result has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic signed [15:0] random_sample(input int unsigned span);
		logic signed [15:0] raw;
		raw = 16'($urandom);
		return raw >>> (16 - span);
	endfunction

	task automatic random_config();
		write_reg(ahpn_pkg::CFG_HP_COEF, $urandom_range(0, 1) ? 16'($urandom_range(26000, 32767))
			: 16'($urandom_range(0, 32767)));
		write_reg(ahpn_pkg::CFG_TARGET, 16'($urandom_range(1000, 32767)));
		write_reg(ahpn_pkg::CFG_FLOOR, ($urandom_range(0, 3) == 0)
			? 16'($urandom_range(0, 32767)) : 16'($urandom_range(0, 300)));
		write_reg(ahpn_pkg::CFG_GAIN_LIMIT, 16'($urandom_range(4096, 65535)));
	endtask

	// chunks of random length and level; a few run up to or past the store size
	task automatic random_phase(input int budget, input bit open_long);
		int               sent;
		int               len;
		int unsigned      span;
		logic signed [15:0] smp;
		sent = 0;
		while (sent < budget) begin
			if (open_long) begin
				len = 70;
				open_long = 1'b0;
			end else if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 3))
					0: len = 63;
					1: len = 64;
					2: len = 65;
					default: len = 70;
				endcase
			end else begin
				len = $urandom_range(1, 12);
			end
			span = ($urandom_range(0, 3) == 0) ? 16 : $urandom_range(2, 14);
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(0, 31) == 0)
					smp = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
				else
					smp = random_sample(span);
				send_sample(smp, k == len - 1);
			end
			sent += len;
		end
	endtask

	// downstream side: short stalls, and one long hold when asked
	initial begin : receiver
		m_tready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (idle_en && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		idle_en = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: zero peak, peak under the floor, capped gain,
		// gain under the cap, then saturating full-scale swings
		send_sample(16'sd0, 1'b1);
		send_sample(16'sd2, 1'b1);
		send_sample(16'sd200, 1'b0);
		send_sample(-16'sd100, 1'b0);
		send_sample(16'sd50, 1'b1);
		send_sample(16'sd6000, 1'b0);
		send_sample(-16'sd1, 1'b1);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh8000, 1'b1);
		send_sample(-16'sd1, 1'b1);
		drain();

		// top of the coefficient, target and limit ranges with zero floor,
		// upper data bit masked off, writes to indexes outside the list dropped
		write_reg(ahpn_pkg::CFG_HP_COEF, 16'hFFFF);
		write_reg(ahpn_pkg::CFG_TARGET, 16'hFFFF);
		write_reg(ahpn_pkg::CFG_FLOOR, 16'h0000);
		write_reg(ahpn_pkg::CFG_GAIN_LIMIT, 16'hFFFF);
		write_reg(CFG_SPARE, 16'h1234);
		write_reg(CFG_TOP_INDEX, 16'h0000);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sd0, 1'b0);
		send_sample(16'sd0, 1'b1);
		drain();

		// gain cap below one: let the filter decay, then a quiet chunk
		write_reg(ahpn_pkg::CFG_HP_COEF, 16'd16384);
		write_reg(ahpn_pkg::CFG_TARGET, 16'd20000);
		write_reg(ahpn_pkg::CFG_FLOOR, 16'd0);
		write_reg(ahpn_pkg::CFG_GAIN_LIMIT, 16'd2048);
		repeat (5) send_sample(16'sd0, 1'b0);
		send_sample(16'sd0, 1'b1);
		send_sample(16'sd500, 1'b0);
		send_sample(-16'sd500, 1'b1);
		drain();

		// zero coefficient and target, floor at the top: filter blocks everything
		write_reg(ahpn_pkg::CFG_HP_COEF, 16'd0);
		write_reg(ahpn_pkg::CFG_TARGET, 16'd0);
		write_reg(ahpn_pkg::CFG_FLOOR, 16'h7FFF);
		write_reg(ahpn_pkg::CFG_GAIN_LIMIT, ahpn_pkg::GAIN_ONE);
		send_sample(16'sd12345, 1'b0);
		send_sample(-16'sd12345, 1'b1);
		drain();

		// random register sets; the third starts with a long hold downstream
		for (int p = 0; p < RAND_SETS; p++) begin
			idle_en = (p != 0 && p != RAND_SETS - 1);
			random_config();
			if (p == 2)
				hold_req = 1'b1;
			random_phase(RAND_ITEMS, p == 2);
			drain();
		end

		$display("%0d samples in %0d chunks, %0d of them scaled; %0d results checked",
			samples_taken, chunks_closed, chunks_scaled, results_checked);
		$display("register sets: reset, range extremes, gain cap under one, %0d random",
			RAND_SETS);
		if (fail_count == 0 && outstanding == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin : watchdog
		#(LIMIT_NS);
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/ahpn_pkg.sv
hdl/ahpn_ram.sv
hdl/ahpn_datapath.sv
hdl/ahpn_ctrl.sv
hdl/audio_highpass_peak_normalizer.sv
dv/ahpn_result_checker.sv
dv/testbench.sv
